// ===== rtl/tcfp_pkg.sv =====
// tcfp_pkg: constants, status codes and the parser-to-fold record for the
// TCP checksum frame patcher. No dependencies.
package tcfp_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 16384;
   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned TL_W = 18;
   localparam int unsigned SUM_W = 32;
   localparam int unsigned ADDR_W = 18;
   localparam int unsigned OFFS_W = 7;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_SHORT_ETH = 3'd1;
   localparam logic [2:0] STATUS_NOT_IPV4 = 3'd2;
   localparam logic [2:0] STATUS_SHORT_IP = 3'd3;
   localparam logic [2:0] STATUS_NOT_TCP = 3'd4;
   localparam logic [2:0] STATUS_SHORT_IHL = 3'd5;
   localparam logic [2:0] STATUS_SHORT_TCP = 3'd6;
   localparam logic [2:0] STATUS_BAD_LEN = 3'd7;

   typedef struct packed {
      logic [2:0] status;
      logic [SUM_W-1:0] payload_sum;
      logic [ADDR_W-1:0] addr_sum;
      logic [15:0] tcp_len;
      logic [OFFS_W-1:0] check_offset;
   } snap_type;

endpackage

// ===== rtl/tcp_checksum_frame_patcher_core.sv =====
// TCP checksum frame patcher, top level: parser stage and fold stage.
// Depends on tcfp_pkg, tcfp_parser and tcfp_fold.
//
// Takes an Ethernet frame one byte per beat and, for each frame-end beat, returns
// one result beat: a status, the TCP checksum over the IPv4 pseudo header and
// segment (check field as zero), and the frame offset of the checksum high byte.
// Checksum and offset are zero unless status is ok. Throughput is one byte per
// cycle while a stalled result side does not hold a frame-end beat; the result
// passes through the input register, then the header/sum register, then the fold
// and result register. Bytes past 16384 are dropped and the frame is judged at that length.
// VLAN tags are not recognized.
module tcp_checksum_frame_patcher_core import tcfp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_frame_byte,
   input  logic req_end_of_frame,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_checksum,
   output logic [6:0] rsp_check_offset
);

   logic snap_valid;
   logic snap_ready;
   snap_type snap;

   tcfp_parser u_parser (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frame_byte(req_frame_byte),
      .req_end_of_frame(req_end_of_frame),
      .snap_valid(snap_valid),
      .snap_ready(snap_ready),
      .snap(snap)
   );

   tcfp_fold u_fold (
      .clock(clock),
      .reset(reset),
      .snap_valid(snap_valid),
      .snap_ready(snap_ready),
      .snap(snap),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_checksum(rsp_checksum),
      .rsp_check_offset(rsp_check_offset)
   );

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_checksum == 16'h0000
         && rsp_check_offset == 7'd0)
      else $error("failed frame carries nonzero checksum or offset");

   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_check_offset >= 7'd30
         && rsp_check_offset[1:0] == 2'b10)
      else $error("check offset outside the TCP header");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(snap_valid))
      else $error("result beat without a parsed frame end");
`endif

endmodule

// ===== rtl/tcfp_parser.sv =====
// tcfp_parser: input beat register, per-byte header capture and running sum,
// frame-end status check. Depends on tcfp_pkg.
module tcfp_parser import tcfp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_frame_byte,
   input  logic req_end_of_frame,
   output logic snap_valid,
   input  logic snap_ready,
   output snap_type snap
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic in_eof_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0] ether_ff, ether_in;
   logic [3:0] hw_ff, hw_in;
   logic [15:0] tot_ff, tot_in;
   logic [7:0] proto_ff, proto_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SUM_W-1:0] psum_ff, psum_in;
   logic [15:0] first_ff, first_in;

   logic snap_valid_ff, snap_valid_in;
   snap_type snap_ff, snap_in;

   logic consume, take;
   logic [7:0] b;
   logic [3:0] hw_eff;
   logic [6:0] start_t;
   logic [POS_W-1:0] k;
   logic signed [TL_W-1:0] tl_t;
   logic [7:0] b_eff;
   logic [15:0] add_a, add_b;

   logic [POS_W-1:0] len;
   logic [6:0] start_f;
   logic [POS_W-1:0] rem;
   logic signed [TL_W-1:0] tl_f;
   logic [2:0] status_f;

   assign consume = in_valid_ff && (!in_eof_ff || !snap_valid_ff || snap_ready);
   assign req_ready = !in_valid_ff || consume;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !consume);
   assign b = in_byte_ff;
   assign take = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign hw_eff = (pos_ff == POS_W'(14)) ? b[3:0] : hw_ff;
   assign start_t = 7'd14 + {1'b0, hw_ff, 2'b00};
   assign k = pos_ff - POS_W'(start_t);
   assign tl_t = $signed({2'b00, tot_ff}) - $signed(TL_W'({hw_ff, 2'b00}));
   assign b_eff = (k == POS_W'(16) || k == POS_W'(17)) ? 8'h00 : b;

   // header capture and running TCP byte sum
   always_comb begin
      pos_in = pos_ff;
      ether_in = ether_ff;
      hw_in = hw_ff;
      tot_in = tot_ff;
      proto_in = proto_ff;
      addr_in = addr_ff;
      psum_in = psum_ff;
      first_in = first_ff;
      add_a = 16'h0000;
      add_b = 16'h0000;
      if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == POS_W'(12)) ether_in = {b, 8'h00};
         if (pos_ff == POS_W'(13)) ether_in = {ether_ff[15:8], b};
         if (pos_ff == POS_W'(14)) begin
            hw_in = b[3:0];
            first_in = {b, 8'h00};
         end
         if (pos_ff == POS_W'(15)) first_in = {first_ff[15:8], b};
         if (pos_ff == POS_W'(16)) tot_in = {b, 8'h00};
         if (pos_ff == POS_W'(17)) tot_in = {tot_ff[15:8], b};
         if (pos_ff == POS_W'(23)) proto_in = b;
         if (pos_ff >= POS_W'(26) && pos_ff <= POS_W'(33)) begin
            addr_in = addr_ff + (pos_ff[0] ? ADDR_W'(b) : ADDR_W'({b, 8'h00}));
         end
         // IHL zero: the segment overlaps the first IP words, counted at offset 17
         if (pos_ff >= POS_W'(14) && pos_ff <= POS_W'(17) && hw_eff == 4'd0) begin
            if (pos_ff == POS_W'(17)) begin
               if (tot_in >= 16'd2) add_a = first_ff;
               else if (tot_in == 16'd1) add_a = {first_ff[15:8], 8'h00};
               if (tot_in >= 16'd4) add_b = tot_in;
               else if (tot_in == 16'd3) add_b = {tot_in[15:8], 8'h00};
               psum_in = psum_ff + SUM_W'(add_a) + SUM_W'(add_b);
            end
         end else if (pos_ff >= POS_W'(18) && pos_ff >= POS_W'(start_t)) begin
            if ($signed(TL_W'(k)) < tl_t) begin
               psum_in = psum_ff + (pos_ff[0] ? SUM_W'(b_eff) : SUM_W'({b_eff, 8'h00}));
            end
         end
      end
   end

   assign len = pos_in;
   assign start_f = 7'd14 + {1'b0, hw_in, 2'b00};
   assign rem = len - POS_W'(start_f);
   assign tl_f = $signed({2'b00, tot_in}) - $signed(TL_W'({hw_in, 2'b00}));

   always_comb begin
      if (len < POS_W'(14)) status_f = STATUS_SHORT_ETH;
      else if (ether_in != ETHERTYPE_IPV4) status_f = STATUS_NOT_IPV4;
      else if (len < POS_W'(34)) status_f = STATUS_SHORT_IP;
      else if (proto_in != PROTO_TCP) status_f = STATUS_NOT_TCP;
      else if (len < POS_W'(start_f)) status_f = STATUS_SHORT_IHL;
      else if (rem < POS_W'(20)) status_f = STATUS_SHORT_TCP;
      else if (tl_f < 0 || tl_f > $signed(TL_W'(rem))) status_f = STATUS_BAD_LEN;
      else status_f = STATUS_OK;
   end

   always_comb begin
      snap_in.status = status_f;
      snap_in.payload_sum = psum_in;
      snap_in.addr_sum = addr_in;
      snap_in.tcp_len = tl_f[15:0];
      snap_in.check_offset = start_f + 7'd16;
   end

   assign snap_valid_in = (consume && in_eof_ff) ? 1'b1 : (snap_valid_ff && !snap_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
      end
      if (req_ready) begin
         in_byte_ff <= req_frame_byte;
         in_eof_ff <= req_end_of_frame;
      end
      if (consume && in_eof_ff) snap_ff <= snap_in;
   end

   // frame state clears after every frame-end beat
   always_ff @(posedge clock) begin
      if (reset || (consume && in_eof_ff)) begin
         pos_ff <= '0;
         ether_ff <= '0;
         hw_ff <= '0;
         tot_ff <= '0;
         proto_ff <= '0;
         addr_ff <= '0;
         psum_ff <= '0;
         first_ff <= '0;
      end else if (consume) begin
         pos_ff <= pos_in;
         ether_ff <= ether_in;
         hw_ff <= hw_in;
         tot_ff <= tot_in;
         proto_ff <= proto_in;
         addr_ff <= addr_in;
         psum_ff <= psum_in;
         first_ff <= first_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap = snap_ff;

endmodule

// ===== rtl/tcfp_fold.sv =====
// tcfp_fold: adds the pseudo header, folds the carries, inverts, and holds the
// result beat. Depends on tcfp_pkg.
module tcfp_fold import tcfp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic snap_valid,
   output logic snap_ready,
   input  snap_type snap,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_checksum,
   output logic [6:0] rsp_check_offset
);

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff;
   logic [15:0] csum_ff, csum_in;
   logic [6:0] offs_ff, offs_in;

   logic [SUM_W-1:0] s;
   logic [16:0] f1;
   logic [15:0] f2;
   logic ok;

   assign ok = snap.status == STATUS_OK;
   assign s = snap.payload_sum + SUM_W'(snap.addr_sum) + SUM_W'(PROTO_TCP)
            + SUM_W'(snap.tcp_len);
   assign f1 = 17'(s[15:0]) + 17'(s[31:16]);
   assign f2 = f1[15:0] + 16'(f1[16]);
   assign csum_in = ok ? ~f2 : 16'h0000;
   assign offs_in = ok ? snap.check_offset : 7'd0;

   assign snap_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = snap_valid ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (snap_valid && snap_ready) begin
         status_ff <= snap.status;
         csum_ff <= csum_in;
         offs_ff <= offs_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_checksum = csum_ff;
   assign rsp_check_offset = offs_ff;

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for tcp_checksum_frame_patcher_core. It streams Ethernet frames
// byte by byte, predicts status, TCP checksum and check offset per frame, and compares them.
// Depends on tcfp_pkg and the core RTL.
module tb_top import tcfp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 700_000;
   localparam int unsigned RANDOM_BYTES = 300;
   localparam int unsigned RANDOM_FRAMES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic last;
   } frame_beat_type;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] checksum;
      logic [6:0] check_offset;
   } tcp_verdict_type;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;
   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_frame_byte = 8'h00;
   logic req_end_of_frame = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [15:0] rsp_checksum;
   logic [6:0] rsp_check_offset;

   tcp_checksum_frame_patcher_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frame_byte(req_frame_byte),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_checksum(rsp_checksum),
      .rsp_check_offset(rsp_check_offset)
   );

   frame_beat_type beats_pending[$];
   tcp_verdict_type verdicts_due[$];

   // frame parser image
   int unsigned pos;
   logic [15:0] eth_type;
   logic [3:0] ihl;
   logic [15:0] tot_len;
   logic [7:0] proto;
   logic [31:0] addr_acc;
   logic [31:0] seg_acc;
   logic [15:0] ver_word;

   int unsigned frames_queued, bytes_queued, bytes_taken, results_checked;
   int unsigned err_count, cycle_count;
   int unsigned status_seen[8];
   logic req_took = 1'b0;
   int unsigned burst_left, gap_left;
   ready_style_type ready_style = RDY_ALWAYS;
   int unsigned ready_style_left, ready_phase;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void clear_frame_state();
      pos = 0;
      eth_type = '0;
      ihl = '0;
      tot_len = '0;
      proto = '0;
      addr_acc = '0;
      seg_acc = '0;
      ver_word = '0;
   endfunction

   function automatic void add_segment_byte(input int unsigned p, input logic [7:0] b);
      int unsigned start;
      int k, tl;
      logic [7:0] v;
      start = 14 + 4 * ihl;
      if (p < start) return;
      k = int'(p - start);
      tl = int'(tot_len) - int'(4 * ihl);
      if (k >= tl) return;
      v = (k == 16 || k == 17) ? 8'h00 : b;    // check field counts as zero
      seg_acc += p[0] ? 32'(v) : 32'({v, 8'h00});
   endfunction

   function automatic void capture_byte(input int unsigned p, input logic [7:0] b);
      if (p == 12) eth_type = {b, 8'h00};
      if (p == 13) eth_type[7:0] = b;
      if (p == 14) begin
         ihl = b[3:0];
         ver_word = {b, 8'h00};
      end
      if (p == 15) ver_word[7:0] = b;
      if (p == 16) tot_len = {b, 8'h00};
      if (p == 17) tot_len[7:0] = b;
      if (p == 23) proto = b;
      if (p >= 26 && p <= 33) addr_acc += p[0] ? 32'(b) : 32'({b, 8'h00});
      // IHL zero: the first four segment bytes are only counted once tot_len is known
      if (p >= 14 && p <= 17 && ihl == 4'd0) begin
         if (p == 17) begin
            if (tot_len >= 2) seg_acc += 32'(ver_word);
            else if (tot_len == 1) seg_acc += 32'(ver_word & 16'hFF00);
            if (tot_len >= 4) seg_acc += 32'(tot_len);
            else if (tot_len == 3) seg_acc += 32'(tot_len & 16'hFF00);
         end
         return;
      end
      if (p >= 14) add_segment_byte(p, b);
   endfunction

   function automatic bit absorb_frame_byte(input logic [7:0] b, input logic last,
                                            output tcp_verdict_type v);
      int unsigned len, start, s;
      int tl;
      v = '{status: STATUS_OK, checksum: 16'h0000, check_offset: 7'd0};
      if (pos < MAX_FRAME_BYTES) begin
         capture_byte(pos, b);
         pos++;
      end
      if (!last) return 1'b0;
      len = pos;
      start = 14 + 4 * ihl;
      tl = int'(tot_len) - int'(4 * ihl);
      if (len < 14) v.status = STATUS_SHORT_ETH;
      else if (eth_type != ETHERTYPE_IPV4) v.status = STATUS_NOT_IPV4;
      else if (len < 34) v.status = STATUS_SHORT_IP;
      else if (proto != PROTO_TCP) v.status = STATUS_NOT_TCP;
      else if (len < start) v.status = STATUS_SHORT_IHL;
      else if (len - start < 20) v.status = STATUS_SHORT_TCP;
      else if (tl < 0 || tl > int'(len - start)) v.status = STATUS_BAD_LEN;
      if (v.status == STATUS_OK) begin
         s = seg_acc + addr_acc + 32'(PROTO_TCP) + 32'(tl);
         while ((s >> 16) != 0) s = (s & 32'hFFFF) + (s >> 16);
         v.checksum = ~s[15:0];
         v.check_offset = 7'(start + 16);
      end
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic int unsigned tcp_frame_len(input int unsigned hw, input int unsigned seg);
      int unsigned n;
      n = 14 + 4 * hw + seg;
      return (n < 34) ? 34 : n;
   endfunction

   task automatic queue_frame(input int unsigned len, input logic [3:0] hw,
                              input logic [15:0] ip_len, input logic [15:0] etype,
                              input logic [7:0] ip_proto, input fill_type fill);
      logic [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default: b = 8'($urandom);
         endcase
         case (i)
            12: b = etype[15:8];
            13: b = etype[7:0];
            14: b = {4'h4, hw};
            16: b = ip_len[15:8];
            17: b = ip_len[7:0];
            23: b = ip_proto;
            default: ;
         endcase
         beats_pending.push_back('{data: b, last: (i == len - 1)});
      end
      frames_queued++;
      bytes_queued += len;
   endtask

   // sender: bursts with random gaps, byte changes on the falling edge
   always @(negedge clock) begin
      frame_beat_type beat;
      if (!reset && (!req_valid || req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (beats_pending.size() > 0) begin
            beat = beats_pending.pop_front();
            req_valid <= 1'b1;
            req_frame_byte <= beat.data;
            req_end_of_frame <= beat.last;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches among four styles at random
   always @(negedge clock) begin
      logic ready_next;
      if (ready_style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         ready_style_left = $urandom_range(20, 300);
      end else begin
         ready_style_left--;
      end
      ready_phase++;
      case (ready_style)
         RDY_ALWAYS: ready_next = 1'b1;
         RDY_COIN: ready_next = 1'($urandom_range(0, 1));
         RDY_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
         default: ready_next = ready_phase[2];
      endcase
      rsp_ready <= reset ? 1'b0 : ready_next;
   end

   // beat monitor: predict on input beats, compare on result beats
   always @(posedge clock) begin
      tcp_verdict_type predicted, due, got;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            bytes_taken++;
            if (absorb_frame_byte(req_frame_byte, req_end_of_frame, predicted))
               verdicts_due.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{status: rsp_status, checksum: rsp_checksum, check_offset: rsp_check_offset};
            if (verdicts_due.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%0t: unexpected result beat status %0d checksum %h offset %0d",
                           $realtime, got.status, got.checksum, got.check_offset);
            end else begin
               due = verdicts_due.pop_front();
               results_checked++;
               status_seen[due.status]++;
               if (got.status !== due.status || got.checksum !== due.checksum ||
                   got.check_offset !== due.check_offset) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("%0t: result %0d expected %0d/%h/%0d got %0d/%h/%0d",
                              $realtime, results_checked, due.status, due.checksum,
                              due.check_offset, got.status, got.checksum, got.check_offset);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  verdicts_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned hw, seg, len, tot, first_bytes, first_frames;
      logic [15:0] etype;
      logic [7:0] ip_proto;
      fill_type fill;

      clear_frame_state();

      // directed frames covering every status code and the header corner cases
      queue_frame(1, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(13, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(14, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(60, 4'd5, 16'd40, 16'h86DD, PROTO_TCP, FILL_RANDOM);
      queue_frame(33, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(60, 4'd5, 16'd40, ETHERTYPE_IPV4, 8'd17, FILL_RANDOM);
      queue_frame(60, 4'd15, 16'd80, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(44, 4'd5, 16'd30, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(54, 4'd5, 16'd41, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(54, 4'd5, 16'd19, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(54, 4'd5, 16'hFFFF, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(54, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_ZERO);
      queue_frame(54, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_ONES);
      queue_frame(55, 4'd5, 16'd41, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(60, 4'd5, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);
      queue_frame(94, 4'd15, 16'd80, ETHERTYPE_IPV4, PROTO_TCP, FILL_ONES);
      for (hw = 0; hw < 5; hw++)
         queue_frame(tcp_frame_len(hw, 20 + hw), 4'(hw), 16'(5 * hw + 20), ETHERTYPE_IPV4,
                     PROTO_TCP, FILL_RANDOM);
      // IHL zero with a tiny total length: partial counting of the first segment bytes
      for (tot = 0; tot < 5; tot++)
         queue_frame(40, 4'd0, 16'(tot), ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);

      // random frames: mostly well formed, some corrupted, some noise
      first_bytes = bytes_queued;
      first_frames = frames_queued;
      while (bytes_queued - first_bytes < RANDOM_BYTES ||
             frames_queued - first_frames < RANDOM_FRAMES) begin
         if ($urandom_range(0, 99) < 10) begin
            queue_frame($urandom_range(1, 70), 4'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), FILL_RANDOM);
         end else begin
            hw = $urandom_range(0, 1) ? 5 : $urandom_range(0, 15);
            seg = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(20, 28);
            len = tcp_frame_len(hw, seg) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            tot = 4 * hw + seg;
            etype = ETHERTYPE_IPV4;
            ip_proto = PROTO_TCP;
            case ($urandom_range(0, 19))
               0: fill = FILL_ZERO;
               1: fill = FILL_ONES;
               default: fill = FILL_RANDOM;
            endcase
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 5))
                  0: etype = 16'($urandom);
                  1: ip_proto = 8'($urandom);
                  2: len = $urandom_range(1, len);
                  3: tot = $urandom_range(0, 16'hFFFF);
                  4: tot = tot + $urandom_range(1, 8);
                  default: tot = $urandom_range(0, 4 * hw + 3);
               endcase
            end
            queue_frame(len, 4'(hw), 16'(tot), etype, ip_proto, fill);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_pending.size() != 0 || req_valid) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d frame bytes in %0d frames, %0d results compared.",
               bytes_taken, frames_queued, results_checked);
      $display("Results per status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d, mismatches %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6], status_seen[7], err_count);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
